/* hw/rtl/first_fit_page_allocator_assert.svh */
// ----------------------------------------------------------------------------
// First-fit page allocator assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ffpa_pkg.sv */
// ----------------------------------------------------------------------------
// ffpa_pkg
// Sizes, types and sequencer states of the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int NUM_PAGES  = 256;
    localparam int PAGE_BYTES = 4096;   // power of two
    localparam int ADDR_W     = 48;
    localparam int COUNT_W    = 9;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int HEAP_W     = PAGE_W + PAGE_SHIFT;
    localparam int IDX_W      = (PAGE_W + 1 > COUNT_W) ? PAGE_W + 1 : COUNT_W;
    localparam int IN_DATA_W  = ((COUNT_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ADDR_W + 7) / 8) * 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam page_t LAST_PAGE = page_t'(NUM_PAGES - 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_ADDR,
        ST_FREE_OFS,
        ST_FREE_CHK,
        ST_FREE_LEN,
        ST_FREE_CLR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  we;
        page_t waddr;
        logic  wdata;
        page_t raddr;
    } used_req_t;

    typedef struct packed {
        logic   we;
        page_t  waddr;
        count_t wdata;
        page_t  raddr;
    } len_req_t;

    typedef struct packed {
        addr_t a;
        addr_t b;
        logic  sub;
    } alu_req_t;

endpackage

/* hw/rtl/ffpa_ram.sv */
// ----------------------------------------------------------------------------
// ffpa_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ffpa_alu.sv */
// ----------------------------------------------------------------------------
// ffpa_alu
// Shared registered address adder/subtractor.
// ----------------------------------------------------------------------------
module ffpa_alu (
    input  logic              clk,
    input  ffpa_pkg::alu_req_t req,
    output ffpa_pkg::addr_t    q
);

    import ffpa_pkg::*;

    addr_t q_reg;
    addr_t q_next;
    addr_t b_eff;

    // Subtract as add of the complement plus one.
    assign b_eff  = req.sub ? ~req.b : req.b;
    assign q_next = req.a + b_eff + addr_t'(req.sub);

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

/* hw/rtl/ffpa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer: clearing pass, bitmap scan, mark/clear sweeps, result register.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  ffpa_pkg::addr_t     heap_base,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_op,
    input  ffpa_pkg::count_t    in_count,
    input  ffpa_pkg::addr_t     in_addr,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_ok,
    output ffpa_pkg::addr_t     out_addr,
    output ffpa_pkg::used_req_t used_req,
    input  logic                used_rdata,
    output ffpa_pkg::len_req_t  len_req,
    input  ffpa_pkg::count_t    len_rdata,
    output ffpa_pkg::alu_req_t  alu_req,
    input  ffpa_pkg::addr_t     alu_q
);

    import ffpa_pkg::*;

    state_t            state_reg, state_next;
    logic [PAGE_W:0]   scan_ptr_reg, scan_ptr_next;
    logic              chk_vld_reg, chk_vld_next;
    page_t             chk_page_reg, chk_page_next;
    count_t            run_reg, run_next;
    count_t            cnt_reg, cnt_next;
    addr_t             addr_in_reg, addr_in_next;
    page_t             wptr_reg, wptr_next;
    count_t            left_reg, left_next;
    page_t             start_reg, start_next;
    logic              res_ok_reg, res_ok_next;
    addr_t             res_addr_reg, res_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    addr_t             out_addr_reg, out_addr_next;

    logic              accept;
    logic              count_bad;
    logic              issue;
    count_t            run_inc;
    logic              hit;
    logic              scan_fail;
    page_t             hit_start;
    logic              in_heap;
    logic              aligned;
    page_t             free_page;
    logic              out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign count_bad = (in_count == '0) || (IDX_W'(in_count) > IDX_W'(NUM_PAGES));

    assign issue     = (state_reg == ST_SCAN) && (scan_ptr_reg < (PAGE_W + 1)'(NUM_PAGES));
    assign run_inc   = run_reg + count_t'(1);
    assign hit       = (state_reg == ST_SCAN) && chk_vld_reg && !used_rdata
                       && (run_inc == cnt_reg);
    assign scan_fail = (state_reg == ST_SCAN) && !chk_vld_reg && !issue;
    assign hit_start = page_t'(IDX_W'(chk_page_reg) + IDX_W'(1) - IDX_W'(cnt_reg));

    // Offset from the heap base sits in the shared adder after ST_FREE_OFS.
    assign free_page = alu_q[PAGE_SHIFT +: PAGE_W];
    assign in_heap   = (alu_q[ADDR_W-1:HEAP_W] == '0) && (free_page <= LAST_PAGE);
    assign aligned   = (alu_q[PAGE_SHIFT-1:0] == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (wptr_reg == LAST_PAGE)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_FREE)
                        state_next = ST_FREE_OFS;
                    else if (count_bad)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                    state_next = ST_MARK;
                else if (scan_fail)
                    state_next = ST_FINISH;
            end
            ST_MARK:
            begin
                if (left_reg == count_t'(1))
                    state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_FINISH;
            end
            ST_FREE_OFS:
            begin
                state_next = ST_FREE_CHK;
            end
            ST_FREE_CHK:
            begin
                if (in_heap && aligned)
                    state_next = ST_FREE_LEN;
                else
                    state_next = ST_FINISH;
            end
            ST_FREE_LEN:
            begin
                if (len_rdata == '0)
                    state_next = ST_FINISH;
                else
                    state_next = ST_FREE_CLR;
            end
            ST_FREE_CLR:
            begin
                if ((left_reg == count_t'(1)) || (wptr_reg == LAST_PAGE))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        scan_ptr_next  = scan_ptr_reg;
        chk_vld_next   = chk_vld_reg;
        chk_page_next  = chk_page_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        addr_in_next   = addr_in_reg;
        wptr_next      = wptr_reg;
        left_next      = left_reg;
        start_next     = start_reg;
        res_ok_next    = res_ok_reg;
        res_addr_next  = res_addr_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_addr_next  = out_addr_reg;

        used_req.we    = 1'b0;
        used_req.waddr = wptr_reg;
        used_req.wdata = 1'b0;
        used_req.raddr = scan_ptr_reg[PAGE_W-1:0];
        len_req.we     = 1'b0;
        len_req.waddr  = wptr_reg;
        len_req.wdata  = '0;
        len_req.raddr  = free_page;
        alu_req.a      = heap_base;
        alu_req.b      = ADDR_W'({start_reg, {PAGE_SHIFT{1'b0}}});
        alu_req.sub    = 1'b0;

        // Drain the output register.
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                used_req.we = 1'b1;
                len_req.we  = 1'b1;
                wptr_next   = wptr_reg + page_t'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next      = in_count;
                    addr_in_next  = in_addr;
                    scan_ptr_next = '0;
                    chk_vld_next  = 1'b0;
                    run_next      = '0;
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                    scan_ptr_next = scan_ptr_reg + (PAGE_W + 1)'(1);
                chk_vld_next  = issue;
                chk_page_next = scan_ptr_reg[PAGE_W-1:0];
                if (chk_vld_reg)
                    run_next = used_rdata ? '0 : run_inc;
                if (hit)
                begin
                    start_next    = hit_start;
                    wptr_next     = hit_start;
                    left_next     = cnt_reg;
                    len_req.we    = 1'b1;
                    len_req.waddr = hit_start;
                    len_req.wdata = cnt_reg;
                end
            end
            ST_MARK:
            begin
                used_req.we    = 1'b1;
                used_req.wdata = 1'b1;
                wptr_next      = wptr_reg + page_t'(1);
                left_next      = left_reg - count_t'(1);
            end
            ST_ADDR:
            begin
                res_ok_next   = 1'b1;
                res_addr_next = alu_q;
            end
            ST_FREE_OFS:
            begin
                alu_req.a   = addr_in_reg;
                alu_req.b   = heap_base;
                alu_req.sub = 1'b1;
            end
            ST_FREE_CHK:
            begin
                res_ok_next = in_heap;
                wptr_next   = free_page;
            end
            ST_FREE_LEN:
            begin
                // Erase the record and load the length to clear.
                len_req.we = 1'b1;
                left_next  = len_rdata;
            end
            ST_FREE_CLR:
            begin
                used_req.we = 1'b1;
                wptr_next   = wptr_reg + page_t'(1);
                left_next   = left_reg - count_t'(1);
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_addr_next  = res_addr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            wptr_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg <= scan_ptr_next;
        chk_page_reg <= chk_page_next;
        run_reg      <= run_next;
        cnt_reg      <= cnt_next;
        addr_in_reg  <= addr_in_next;
        left_reg     <= left_next;
        start_reg    <= start_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        out_ok_reg   <= out_ok_next;
        out_addr_reg <= out_addr_next;
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_addr  = out_addr_reg;

endmodule

/* hw/rtl/first_fit_page_allocator.sv */
// Allocate: scans k pages of the bitmap, marks the N pages found and forms the address; a failed
//   scan covers all NUM_PAGES pages, a bad count skips it; free clears the L pages of the block.
// A new request is taken only once the previous result is in the output register; the page
//   bitmap is read once per page during the scan and written once per page during mark/clear.
// Reset: asynchronous, active low; a clearing pass over all NUM_PAGES (256) pages then
//   zeroes the bitmap and length table before the first request is taken.
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit contiguous page allocator over a used-page bitmap.
// ----------------------------------------------------------------------------
module first_fit_page_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  ffpa_pkg::addr_t                   cfg_wdata,     // heap_base
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ffpa_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // page_count, free_address
    input  logic                              s_axis_tuser,  // op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ffpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // block_address
    output logic                              m_axis_tuser   // ok
);

    import ffpa_pkg::*;

    `include "first_fit_page_allocator_assert.svh"

    addr_t     heap_base_reg;
    addr_t     heap_base_next;
    used_req_t used_req;
    len_req_t  len_req;
    alu_req_t  alu_req;
    addr_t     alu_q;
    logic      used_rdata;
    count_t    len_rdata;
    addr_t     out_addr;
    addr_t     out_ofs;

    assign heap_base_next = cfg_we ? cfg_wdata : heap_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heap_base_reg <= '0;
        else
            heap_base_reg <= heap_base_next;
    end

    ffpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .heap_base  (heap_base_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_count   (s_axis_tdata[COUNT_W-1:0]),
        .in_addr    (s_axis_tdata[COUNT_W +: ADDR_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_ok     (m_axis_tuser),
        .out_addr   (out_addr),
        .used_req   (used_req),
        .used_rdata (used_rdata),
        .len_req    (len_req),
        .len_rdata  (len_rdata),
        .alu_req    (alu_req),
        .alu_q      (alu_q)
    );

    ffpa_ram #(
        .WIDTH (1),
        .DEPTH (NUM_PAGES)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_req.we),
        .waddr (used_req.waddr),
        .wdata (used_req.wdata),
        .raddr (used_req.raddr),
        .rdata (used_rdata)
    );

    ffpa_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_PAGES)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_req.we),
        .waddr (len_req.waddr),
        .wdata (len_req.wdata),
        .raddr (len_req.raddr),
        .rdata (len_rdata)
    );

    ffpa_alu u_alu (
        .clk (clk),
        .req (alu_req),
        .q   (alu_q)
    );

    assign m_axis_tdata = OUT_DATA_W'(out_addr);
    assign out_ofs      = out_addr - heap_base_reg;

    `FFPA_ASSERT_NEXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted but allocator still ready")
    `FFPA_ASSERT_NOW(a_idle_no_mem_write, s_axis_tready, !used_req.we && !len_req.we, "memory write while idle")
    `FFPA_ASSERT_NOW(a_block_page_aligned, m_axis_tvalid, (out_addr == '0) || (out_ofs[PAGE_SHIFT-1:0] == '0), "block address not on a page boundary")

endmodule
